[sv/ibds_pkg.sv]
// ---------------------------------------------------------------------------
// ibds_pkg: shared types and constants for the baud divider search
// Divider table, field widths, sequencer states and divider unit structs.
// ---------------------------------------------------------------------------
package ibds_pkg;

   localparam int CLOCK_W       = 27;
   localparam int TARGET_W      = 12;
   localparam int HZ_W          = 22;
   localparam int ERR_W         = 27;
   localparam int BEST_W        = ERR_W + 1;
   localparam int MULT_W        = 2;
   localparam int CODE_W        = 6;
   localparam int DIVIDE_W      = 12;
   localparam int DEN_W         = 14;
   localparam int DIV_IDX_W     = 6;
   localparam int DIV_TABLE_LEN = 50;
   localparam int DIV_STEPS     = CLOCK_W;
   localparam int STEP_W        = 5;

   localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(24000000);
   localparam logic [HZ_W-1:0]    KBPS_SCALE  = HZ_W'(1000);
   localparam logic [MULT_W-1:0]  MULT_LAST   = MULT_W'(2);

   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [DIVIDE_W-1:0] divide;
   } div_entry_type;

   localparam div_entry_type DIV_TABLE [DIV_TABLE_LEN] = '{
      '{6'h00, 12'd20},   '{6'h01, 12'd22},   '{6'h02, 12'd24},   '{6'h03, 12'd26},
      '{6'h04, 12'd28},   '{6'h05, 12'd30},   '{6'h09, 12'd32},   '{6'h06, 12'd34},
      '{6'h0a, 12'd36},   '{6'h07, 12'd40},   '{6'h0c, 12'd44},   '{6'h10, 12'd48},
      '{6'h11, 12'd56},   '{6'h12, 12'd64},   '{6'h0f, 12'd68},   '{6'h13, 12'd72},
      '{6'h14, 12'd80},   '{6'h15, 12'd88},   '{6'h19, 12'd96},   '{6'h16, 12'd104},
      '{6'h1a, 12'd112},  '{6'h17, 12'd128},  '{6'h1c, 12'd144},  '{6'h1d, 12'd160},
      '{6'h1e, 12'd192},  '{6'h22, 12'd224},  '{6'h1f, 12'd240},  '{6'h23, 12'd256},
      '{6'h24, 12'd288},  '{6'h25, 12'd320},  '{6'h26, 12'd384},  '{6'h2a, 12'd448},
      '{6'h27, 12'd480},  '{6'h2b, 12'd512},  '{6'h2c, 12'd576},  '{6'h2d, 12'd640},
      '{6'h2e, 12'd768},  '{6'h32, 12'd896},  '{6'h2f, 12'd960},  '{6'h33, 12'd1024},
      '{6'h34, 12'd1152}, '{6'h35, 12'd1280}, '{6'h36, 12'd1536}, '{6'h3a, 12'd1792},
      '{6'h37, 12'd1920}, '{6'h3b, 12'd2048}, '{6'h3c, 12'd2304}, '{6'h3d, 12'd2560},
      '{6'h3e, 12'd3072}, '{6'h3f, 12'd3840}
   };

   function automatic div_entry_type div_entry(input logic [DIV_IDX_W-1:0] idx);
      div_entry_type e;
      if (idx < DIV_IDX_W'(DIV_TABLE_LEN)) begin
         e = DIV_TABLE[idx];
      end else begin
         e = DIV_TABLE[0];
      end
      return e;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               start;
      logic [CLOCK_W-1:0] dividend;
      logic [DEN_W-1:0]   divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [CLOCK_W-1:0] quotient;
   } div_rsp_type;

endpackage

[sv/ibds_if.sv]
// ---------------------------------------------------------------------------
// ibds channel interfaces
// Valid/ready channels for the request, the response and the clock register.
// ---------------------------------------------------------------------------
interface ibds_req_if;
   import ibds_pkg::*;
   logic                valid;
   logic                ready;
   logic [TARGET_W-1:0] target_kbps;
   modport source (output valid, output target_kbps, input ready);
   modport sink   (input valid, input target_kbps, output ready);
endinterface

interface ibds_rsp_if;
   import ibds_pkg::*;
   logic              valid;
   logic              ready;
   logic [MULT_W-1:0] mult_select;
   logic [CODE_W-1:0] divider_code;
   logic [ERR_W-1:0]  abs_error_hz;
   modport source (output valid, output mult_select, output divider_code,
                   output abs_error_hz, input ready);
   modport sink   (input valid, input mult_select, input divider_code,
                   input abs_error_hz, output ready);
endinterface

interface ibds_csr_if;
   import ibds_pkg::*;
   logic               valid;
   logic               ready;
   logic [CLOCK_W-1:0] bus_clock_hz;
   modport source (output valid, output bus_clock_hz, input ready);
   modport sink   (input valid, input bus_clock_hz, output ready);
endinterface

[sv/ibds_div.sv]
// ---------------------------------------------------------------------------
// ibds_div: restoring divider, one quotient bit per cycle
// Divides the bus clock by a candidate denominator.
// ---------------------------------------------------------------------------
module ibds_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ibds_pkg::div_cmd_type cmd,
   output ibds_pkg::div_rsp_type rsp
);
   import ibds_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   count_ff, count_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    dsr_ff, dsr_in;
   logic [CLOCK_W-1:0]  quo_ff, quo_in;

   logic [DEN_W:0]      partial;
   logic [DEN_W:0]      diff;
   logic                fits;

   // dividend shifts out of the top of quo_ff while quotient bits enter below
   assign partial = {rem_ff, quo_ff[CLOCK_W-1]};
   assign diff    = partial - {1'b0, dsr_ff};
   assign fits    = partial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = STEP_W'(DIV_STEPS - 1);
         rem_in   = '0;
         dsr_in   = cmd.divisor;
         quo_in   = cmd.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
         quo_in = {quo_ff[CLOCK_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      quo_ff   <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[sv/i2c_baud_divider_search.sv]
// Each candidate runs start, the divider steps, the done flag and the compare;
// up to 3 * TABLE_ENTRIES candidates plus a finish state lie between accept
// and response, fewer on an exact match. One request at a time; the next is
// taken after the result moves to the response register, which waits while a
// response is still pending. The response register frees the search for the next request.
// Synchronous active-high reset: idle, no response pending, clock 24 MHz.
// ---------------------------------------------------------------------------
// i2c_baud_divider_search: best clock divider table search
// Sweeps multiplier and divider table, keeps the lowest rate error.
// ---------------------------------------------------------------------------
module i2c_baud_divider_search #(
   parameter int TABLE_ENTRIES = 50
) (
   input  logic        clock,
   input  logic        reset,
   ibds_req_if.sink    req,
   ibds_rsp_if.source  rsp,
   ibds_csr_if.sink    csr
);
   import ibds_pkg::*;

   localparam int ENTRY_COUNT = (TABLE_ENTRIES > DIV_TABLE_LEN) ? DIV_TABLE_LEN
                                                                 : TABLE_ENTRIES;
   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRY_COUNT - 1);

   state_type state_ff, state_in;

   logic [CLOCK_W-1:0] bus_clock_ff;
   logic [HZ_W-1:0]    hz_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [MULT_W-1:0]  mult_ff;
   logic [BEST_W-1:0]  best_ff;
   logic [MULT_W-1:0]  best_mult_ff;
   logic [CODE_W-1:0]  best_code_ff;

   logic               rsp_valid_ff;
   logic [MULT_W-1:0]  rsp_mult_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic [ERR_W-1:0]   rsp_err_ff;

   div_entry_type      entry;
   div_cmd_type        div_cmd;
   div_rsp_type        div_rsp;

   logic [ERR_W-1:0]   hz_ext;
   logic [ERR_W-1:0]   err;
   logic               better;
   logic               finish;
   logic               out_free;
   logic               load_job;
   logic               div_start;
   logic               eval_en;
   logic               load_rsp;

   ibds_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign entry    = div_entry(DIV_IDX_W'(idx_ff));
   assign hz_ext   = ERR_W'(hz_ff);
   assign err      = (hz_ext > div_rsp.quotient) ? (hz_ext - div_rsp.quotient)
                                                 : (div_rsp.quotient - hz_ext);
   assign better   = {1'b0, err} < best_ff;
   assign finish   = (better && (err == '0)) || ((idx_ff == IDX_LAST) && (mult_ff == MULT_LAST));
   assign out_free = !rsp_valid_ff || rsp.ready;

   assign div_cmd.start    = div_start;
   assign div_cmd.dividend = bus_clock_ff;
   assign div_cmd.divisor  = DEN_W'(entry.divide) << mult_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req.valid) state_in = ST_START;
         ST_START:  state_in = ST_WAIT;
         ST_WAIT:   if (div_rsp.done) state_in = ST_EVAL;
         ST_EVAL:   state_in = finish ? ST_FINISH : ST_START;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req.ready = 1'b0;
      div_start = 1'b0;
      eval_en   = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req.ready = !reset;
         ST_START:  div_start = 1'b1;
         ST_WAIT:   ;
         ST_EVAL:   eval_en   = 1'b1;
         ST_FINISH: load_rsp  = out_free;
         default:   ;
      endcase
   end

   assign load_job = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bus_clock_ff <= CLOCK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready) begin
            bus_clock_ff <= csr.bus_clock_hz;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_job) begin
         hz_ff   <= HZ_W'({10'd0, req.target_kbps} * KBPS_SCALE);
         idx_ff  <= '0;
         mult_ff <= '0;
         best_ff <= '1;
      end else if (eval_en) begin
         if (better) begin
            best_ff      <= {1'b0, err};
            best_mult_ff <= mult_ff;
            best_code_ff <= entry.code;
         end
         if (idx_ff == IDX_LAST) begin
            idx_ff  <= '0;
            mult_ff <= mult_ff + 1'b1;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
      if (load_rsp) begin
         rsp_mult_ff <= best_mult_ff;
         rsp_code_ff <= best_code_ff;
         rsp_err_ff  <= best_ff[ERR_W-1:0];
      end
   end

   // clock register only changes between searches
   assign csr.ready        = !reset && (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.mult_select  = rsp_mult_ff;
   assign rsp.divider_code = rsp_code_ff;
   assign rsp.abs_error_hz = rsp_err_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == ST_START))
      else $error("accepted request did not start the divider");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_WAIT))
      else $error("divider finished outside the wait state");

   a_best_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (best_ff[ERR_W] == 1'b0))
      else $error("search finished without a candidate");

   a_mult_range: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_mult_ff != 2'd3))
      else $error("multiplier select out of range");

endmodule

[sim/tb_i2c_baud_divider_search.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_i2c_baud_divider_search: self-checking bench for the baud divider search
// Drives bit rate requests and bus clock writes with random gaps and stalls.
// Each response is checked against an in-bench sweep of multiplier and
// divider table for the bus clock in force when the request was accepted.
// ---------------------------------------------------------------------------
module tb_i2c_baud_divider_search;
   import ibds_pkg::*;

   localparam int TABLE_ENTRIES = 50;
   localparam logic [CLOCK_W-1:0] CLOCK_ALL_ONES = {CLOCK_W{1'b1}};

   typedef struct packed {
      logic [TARGET_W-1:0] kbps;
      logic [MULT_W-1:0]   mult;
      logic [CODE_W-1:0]   code;
      logic [ERR_W-1:0]    err;
   } divider_choice_type;

   logic clock;
   logic reset;

   ibds_req_if req_ch ();
   ibds_rsp_if rsp_ch ();
   ibds_csr_if csr_ch ();

   i2c_baud_divider_search #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   divider_choice_type pending_choices[$];
   logic [CLOCK_W-1:0] bus_clock_cfg;
   int                 errors;
   int                 responses_checked;
   int                 exact_hits;
   int                 mult_hits[3];
   int                 clock_settings;
   bit                 quiet_mode;
   int                 stall_left;
   divider_choice_type want;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #40_000_000;
      $display("Timeout with %0d responses outstanding", pending_choices.size());
      $display("DONE: errors detected");
      $finish;
   end

   // Sweep exponent outer, table inner; keep first strictly lower error,
   // stop everything on an exact hit.
   function automatic divider_choice_type best_divider(input logic [CLOCK_W-1:0] clk_hz,
                                                       input logic [TARGET_W-1:0] kbps);
      divider_choice_type pick;
      int unsigned        target_hz;
      int unsigned        best_err;
      int unsigned        den;
      int unsigned        rate;
      int unsigned        err;
      int unsigned        n;
      bit                 hit;
      target_hz = 32'(kbps) * 1000;
      n         = (TABLE_ENTRIES > DIV_TABLE_LEN) ? DIV_TABLE_LEN : TABLE_ENTRIES;
      best_err  = 32'hFFFF_FFFF;
      hit       = 1'b0;
      pick      = '0;
      pick.kbps = kbps;
      for (int m = 0; m < 3 && !hit; m++) begin
         for (int i = 0; i < n && !hit; i++) begin
            den  = (32'd1 << m) * 32'(DIV_TABLE[i].divide);
            rate = 32'(clk_hz) / den;
            err  = (target_hz > rate) ? target_hz - rate : rate - target_hz;
            if (err < best_err) begin
               best_err  = err;
               pick.mult = MULT_W'(m);
               pick.code = DIV_TABLE[i].code;
               hit       = (err == 0);
            end
         end
      end
      pick.err = ERR_W'(best_err);
      return pick;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // Response side back-pressure
   always @(negedge clock) begin
      if (reset || quiet_mode) begin
         rsp_ch.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70)
                                                     : $urandom_range(1, 3);
         end
      end
   end

   task automatic report(input string field, input int unsigned exp_v,
                         input int unsigned act_v, input logic [TARGET_W-1:0] kbps);
      $display("%0t: %s mismatch for %0d kbps, expected %0d, got %0d",
               $time, field, kbps, exp_v, act_v);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_choices.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, got %0d/%0h/%0d",
                     $time, rsp_ch.mult_select, rsp_ch.divider_code, rsp_ch.abs_error_hz);
            errors++;
         end else begin
            want = pending_choices.pop_front();
            if (rsp_ch.mult_select !== want.mult)
               report("mult_select", want.mult, rsp_ch.mult_select, want.kbps);
            if (rsp_ch.divider_code !== want.code)
               report("divider_code", want.code, rsp_ch.divider_code, want.kbps);
            if (rsp_ch.abs_error_hz !== want.err)
               report("abs_error_hz", want.err, rsp_ch.abs_error_hz, want.kbps);
            responses_checked++;
            if (want.err == 0) exact_hits++;
            mult_hits[want.mult]++;
         end
      end
   end

   // Leaves valid high after acceptance; a drain, or the next call when it waits a gap, lowers it.
   task automatic send_request(input logic [TARGET_W-1:0] kbps);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.target_kbps <= kbps;
      do @(posedge clock); while (!req_ch.ready);
      pending_choices.push_back(best_divider(bus_clock_cfg, kbps));
   endtask

   task automatic drain_requests();
      @(negedge clock) req_ch.valid <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
   endtask

   task automatic write_bus_clock(input logic [CLOCK_W-1:0] hz);
      drain_requests();
      @(negedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.bus_clock_hz <= hz;
      do @(posedge clock); while (!csr_ch.ready);
      bus_clock_cfg = hz;
      clock_settings++;
      @(negedge clock) csr_ch.valid <= 1'b0;
   endtask

   // Reset clock of 24 MHz: exact hits on first entry and mid table,
   // zero target, top target and alternating bit patterns.
   task automatic test_reset_clock();
      send_request(12'd1200);
      send_request(12'd100);
      send_request(12'd0);
      send_request(12'd4095);
      send_request(12'd1);
      send_request(12'd400);
      send_request(12'd2730);
      send_request(12'd1365);
   endtask

   // Dead bus clock: every candidate gives rate zero, first entry wins.
   task automatic test_zero_clock();
      write_bus_clock('0);
      send_request(12'd0);
      send_request(12'd4095);
      send_request(12'd777);
   endtask

   task automatic test_clock_extremes();
      write_bus_clock(CLOCK_ALL_ONES);
      send_request(12'd4095);
      send_request(12'd1);
      send_request(12'd2048);
      write_bus_clock(CLOCK_W'(1));
      send_request(12'd0);
      send_request(12'd1);
      write_bus_clock(CLOCK_W'(100_000_000));
      send_request(12'd4000);
      send_request(12'd3333);
   endtask

   // 15.36 MHz puts exact hits at the last table entry for each exponent.
   task automatic test_exact_multiplier();
      write_bus_clock(CLOCK_W'(15_360_000));
      send_request(12'd1);
      send_request(12'd2);
      send_request(12'd4);
   endtask

   task automatic test_random_sweep();
      logic [CLOCK_W-1:0] hz;
      int unsigned        den;
      int                 t;
      int                 r;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: hz = CLOCK_W'($urandom_range(8_000_000, 100_000_000));
            1: hz = CLOCK_W'(46_080_000);
            2: hz = CLOCK_W'($urandom);
            default: hz = CLOCK_W'(1000 * $urandom_range(20, 134_000));
         endcase
         write_bus_clock(hz);
         quiet_mode = (phase == 1);
         for (int k = 0; k < 25; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               // aim near an achievable rate so the search has real competition
               den = (32'd1 << $urandom_range(0, 2))
                     * 32'(DIV_TABLE[$urandom_range(0, DIV_TABLE_LEN - 1)].divide);
               t = int'((32'(hz) / den) / 1000) + $urandom_range(0, 2) - 1;
               if (t < 0 || t > 4095) t = $urandom_range(0, 4095);
            end else if (r < 70) begin
               t = ($urandom_range(0, 1) == 0) ? 0 : 4095;
            end else begin
               t = $urandom_range(0, 4095);
            end
            send_request(TARGET_W'(t));
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.target_kbps  = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.bus_clock_hz = '0;
      bus_clock_cfg       = CLOCK_RESET;
      errors              = 0;
      responses_checked   = 0;
      exact_hits          = 0;
      mult_hits           = '{0, 0, 0};
      clock_settings      = 1;
      quiet_mode          = 1'b0;
      stall_left          = 0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_reset_clock();
      test_zero_clock();
      test_clock_extremes();
      test_exact_multiplier();
      test_random_sweep();

      drain_requests();
      repeat (40) @(posedge clock);

      $display("Covered %0d responses under %0d bus clock settings, %0d exact matches",
               responses_checked, clock_settings, exact_hits);
      $display("Chosen multiplier exponents 0/1/2: %0d/%0d/%0d",
               mult_hits[0], mult_hits[1], mult_hits[2]);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
